// File: design/cmtt_pkg.sv
// ----------------------------------------------------------------------------
// CAN motor telemetry and throttle package
// Shared types, codes and constants of the motor link handler.
// ----------------------------------------------------------------------------
package cmtt_pkg;

    localparam int MOTOR_COUNT = 8;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [28:0] SPEED_BASE_ID = 29'h189D271C;
    localparam logic [28:0] TEMP_BASE_ID  = 29'h18A1271C;
    localparam logic [15:0] STALE_MARK    = 16'hFFFF;
    localparam logic [31:0] PAYLOAD_FILL  = 32'hFFFFFFFF;

    localparam logic [15:0] CMD_PERIOD_RESET  = 16'd20;
    localparam logic [15:0] STALE_LIMIT_RESET = 16'd1000;

    localparam logic [28:0] THROTTLE_ID [8] = '{
        29'h14661C27, 29'h14671C27, 29'h14681C27, 29'h14691C27,
        29'h14761C27, 29'h14771C27, 29'h14781C27, 29'h14791C27
    };

    localparam logic [1:0] ACT_FRAME    = 2'd0;
    localparam logic [1:0] ACT_THROTTLE = 2'd1;
    localparam logic [1:0] ACT_UPDATE   = 2'd2;

    localparam logic KIND_THROTTLE = 1'b0;
    localparam logic KIND_STATUS   = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_CMD_PERIOD  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STALE_LIMIT = 1'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMD,
        ST_STAT
    } state_t;

    typedef struct packed {
        logic       accept;
        logic       step_cmd;
        logic       emit_frame;
        logic       emit_status;
        logic       last;
        logic [2:0] motor;
    } ctrl_cmd_t;

    typedef struct packed {
        logic cmd_due;
        logic pending;
    } ctrl_status_t;

endpackage

// File: design/can_motor_telemetry_and_throttle_core.sv
// ----------------------------------------------------------------------------
// CAN motor telemetry and throttle core
// Link handler for eight motor controllers: stores received speed and
// temperature frames, latches throttle commands and, on each update, emits
// due throttle frames followed by one status record per motor.
// ----------------------------------------------------------------------------
// A received frame or a set-throttle item is absorbed in the cycle of its
// transfer, so the next item may follow in the next cycle. An update item
// holds the input after its transfer while the controller walks the
// motors one per cycle through a single period compare and then one per
// cycle through the staleness compare; a step that emits a result waits
// while the previous result is still held by out_stall.
module can_motor_telemetry_and_throttle_core
    import cmtt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [1:0]             action,
    input  logic [31:0]            now_ms,
    input  logic [28:0]            frame_id,
    input  logic                   frame_extended,
    input  logic [63:0]            frame_payload,
    input  logic [2:0]             motor_index,
    input  logic [15:0]            throttle,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   kind,
    output logic [2:0]             motor_id,
    output logic [28:0]            tx_id,
    output logic [63:0]            tx_payload,
    output logic [15:0]            speed_a,
    output logic [15:0]            speed_b,
    output logic [15:0]            temp_a,
    output logic [15:0]            temp_b,
    output logic                   last
);

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    cmtt_controller u_controller (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    cmtt_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .action         (action),
        .now_ms         (now_ms),
        .frame_id       (frame_id),
        .frame_extended (frame_extended),
        .frame_payload  (frame_payload),
        .motor_index    (motor_index),
        .throttle       (throttle),
        .kind           (kind),
        .motor_id       (motor_id),
        .tx_id          (tx_id),
        .tx_payload     (tx_payload),
        .speed_a        (speed_a),
        .speed_b        (speed_b),
        .temp_a         (temp_a),
        .temp_b         (temp_b),
        .last           (last)
    );

endmodule

// File: design/cmtt_controller.sv
// ----------------------------------------------------------------------------
// CAN motor telemetry and throttle controller
// Sequences an update over the command walk and the status walk, one motor
// per step, and owns the result valid flag.
// ----------------------------------------------------------------------------
module cmtt_controller
    import cmtt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic [1:0]   action,
    output logic         out_valid,
    input  logic         out_stall,
    input  ctrl_status_t status,
    output ctrl_cmd_t    cmd
);

    state_t     state_reg;
    state_t     state_next;
    logic [2:0] motor_reg;
    logic [2:0] motor_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;
    logic       at_last;
    logic       advance;

    assign out_free = !out_valid_reg || !out_stall;
    assign at_last  = (motor_reg == 3'(MOTOR_COUNT - 1));

    always_comb
    begin
        case (state_reg)
            ST_CMD:  advance = !(status.cmd_due && status.pending) || out_free;
            ST_STAT: advance = out_free;
            default: advance = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        motor_next = motor_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && action == ACT_UPDATE)
                begin
                    state_next = ST_CMD;
                    motor_next = 3'd0;
                end
            end
            ST_CMD:
            begin
                if (advance)
                begin
                    if (at_last)
                    begin
                        state_next = ST_STAT;
                        motor_next = 3'd0;
                    end
                    else
                    begin
                        motor_next = motor_reg + 3'd1;
                    end
                end
            end
            ST_STAT:
            begin
                if (advance)
                begin
                    if (at_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        motor_next = motor_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd             = '0;
        cmd.motor       = motor_reg;
        in_stall        = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
            end
            ST_CMD:
            begin
                cmd.step_cmd   = advance;
                cmd.emit_frame = advance && status.cmd_due && status.pending;
            end
            ST_STAT:
            begin
                cmd.emit_status = advance;
                cmd.last        = at_last;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.emit_frame || cmd.emit_status)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            motor_reg     <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            motor_reg     <= motor_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: design/cmtt_datapath.sv
// ----------------------------------------------------------------------------
// CAN motor telemetry and throttle datapath
// Telemetry and throttle state, configuration registers, the period and
// staleness compares for the selected motor, and the result register.
// ----------------------------------------------------------------------------
module cmtt_datapath
    import cmtt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  ctrl_cmd_t              cmd,
    output ctrl_status_t           status,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [1:0]             action,
    input  logic [31:0]            now_ms,
    input  logic [28:0]            frame_id,
    input  logic                   frame_extended,
    input  logic [63:0]            frame_payload,
    input  logic [2:0]             motor_index,
    input  logic [15:0]            throttle,
    output logic                   kind,
    output logic [2:0]             motor_id,
    output logic [28:0]            tx_id,
    output logic [63:0]            tx_payload,
    output logic [15:0]            speed_a,
    output logic [15:0]            speed_b,
    output logic [15:0]            temp_a,
    output logic [15:0]            temp_b,
    output logic                   last
);

    logic [15:0] cmd_period_reg;
    logic [15:0] stale_limit_reg;
    logic [31:0] now_reg;

    logic [31:0] speed_word_reg [8];
    logic [31:0] temp_word_reg  [8];
    logic [31:0] speed_stamp_reg [8];
    logic [31:0] temp_stamp_reg  [8];
    logic [31:0] cmd_stamp_reg   [8];
    logic [15:0] throttle_value_reg [8];
    logic [7:0]  pending_reg;

    logic        kind_reg;
    logic [2:0]  motor_id_reg;
    logic [28:0] tx_id_reg;
    logic [63:0] tx_payload_reg;
    logic [15:0] speed_a_reg;
    logic [15:0] speed_b_reg;
    logic [15:0] temp_a_reg;
    logic [15:0] temp_b_reg;
    logic        last_reg;

    logic [28:0] speed_diff;
    logic [28:0] temp_diff;
    logic        speed_hit;
    logic        temp_hit;
    logic [2:0]  speed_slot;
    logic [2:0]  temp_slot;
    logic        frame_ok;
    logic        throttle_ok;
    logic [31:0] cmd_age;
    logic [31:0] speed_age;
    logic [31:0] temp_age;
    logic        speed_fresh;
    logic        temp_fresh;
    logic [15:0] thr_sel;

    assign speed_diff = frame_id - SPEED_BASE_ID;
    assign temp_diff  = frame_id - TEMP_BASE_ID;
    assign speed_hit  = (speed_diff[28:18] == 11'd0) && (speed_diff[15:0] == 16'd0);
    assign temp_hit   = (temp_diff[28:18] == 11'd0) && (temp_diff[15:0] == 16'd0);
    assign speed_slot = {speed_diff[17:16], 1'b0};
    assign temp_slot  = {temp_diff[17:16], 1'b0};
    assign frame_ok   = cmd.accept && action == ACT_FRAME && frame_extended;
    assign throttle_ok = cmd.accept && action == ACT_THROTTLE
                         && ({1'b0, motor_index} < 4'(MOTOR_COUNT));

    assign cmd_age     = now_reg - cmd_stamp_reg[cmd.motor];
    assign speed_age   = now_reg - speed_stamp_reg[cmd.motor];
    assign temp_age    = now_reg - temp_stamp_reg[cmd.motor];
    assign speed_fresh = speed_age < {16'd0, stale_limit_reg};
    assign temp_fresh  = temp_age < {16'd0, stale_limit_reg};
    assign thr_sel     = throttle_value_reg[cmd.motor];

    assign status.cmd_due = cmd_age > {16'd0, cmd_period_reg};
    assign status.pending = pending_reg[cmd.motor];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_period_reg  <= CMD_PERIOD_RESET;
            stale_limit_reg <= STALE_LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_CMD_PERIOD:  cmd_period_reg  <= cfg_data;
                CFG_STALE_LIMIT: stale_limit_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg     <= 32'd0;
            pending_reg <= 8'd0;
            for (int i = 0; i < 8; i++)
            begin
                speed_word_reg[i]     <= 32'd0;
                temp_word_reg[i]      <= 32'd0;
                speed_stamp_reg[i]    <= 32'd0;
                temp_stamp_reg[i]     <= 32'd0;
                cmd_stamp_reg[i]      <= 32'd0;
                throttle_value_reg[i] <= 16'd0;
            end
        end
        else
        begin
            if (cmd.accept)
            begin
                now_reg <= now_ms;
            end
            if (frame_ok && speed_hit)
            begin
                speed_word_reg[speed_slot]         <= frame_payload[63:32];
                speed_word_reg[speed_slot + 3'd1]  <= frame_payload[31:0];
                speed_stamp_reg[speed_slot]        <= now_ms;
                speed_stamp_reg[speed_slot + 3'd1] <= now_ms;
            end
            else if (frame_ok && temp_hit)
            begin
                temp_word_reg[temp_slot]          <= frame_payload[63:32];
                temp_word_reg[temp_slot + 3'd1]   <= frame_payload[31:0];
                temp_stamp_reg[temp_slot]         <= now_ms;
                temp_stamp_reg[temp_slot + 3'd1]  <= now_ms;
            end
            if (throttle_ok)
            begin
                throttle_value_reg[motor_index] <= throttle;
                pending_reg[motor_index]        <= 1'b1;
            end
            if (cmd.step_cmd && status.cmd_due)
            begin
                cmd_stamp_reg[cmd.motor] <= now_reg;
            end
            if (cmd.emit_frame)
            begin
                pending_reg[cmd.motor] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_frame)
        begin
            kind_reg       <= KIND_THROTTLE;
            motor_id_reg   <= cmd.motor;
            tx_id_reg      <= THROTTLE_ID[cmd.motor];
            tx_payload_reg <= {thr_sel, thr_sel, PAYLOAD_FILL};
            speed_a_reg    <= 16'd0;
            speed_b_reg    <= 16'd0;
            temp_a_reg     <= 16'd0;
            temp_b_reg     <= 16'd0;
            last_reg       <= 1'b0;
        end
        else if (cmd.emit_status)
        begin
            kind_reg       <= KIND_STATUS;
            motor_id_reg   <= cmd.motor;
            tx_id_reg      <= 29'd0;
            tx_payload_reg <= 64'd0;
            speed_a_reg    <= speed_fresh ? speed_word_reg[cmd.motor][31:16] : STALE_MARK;
            speed_b_reg    <= speed_fresh ? speed_word_reg[cmd.motor][15:0]  : STALE_MARK;
            temp_a_reg     <= temp_fresh ? temp_word_reg[cmd.motor][31:16] : STALE_MARK;
            temp_b_reg     <= temp_fresh ? temp_word_reg[cmd.motor][15:0]  : STALE_MARK;
            last_reg       <= cmd.last;
        end
    end

    assign kind       = kind_reg;
    assign motor_id   = motor_id_reg;
    assign tx_id      = tx_id_reg;
    assign tx_payload = tx_payload_reg;
    assign speed_a    = speed_a_reg;
    assign speed_b    = speed_b_reg;
    assign temp_a     = temp_a_reg;
    assign temp_b     = temp_b_reg;
    assign last       = last_reg;

endmodule
